// ----- rtl/core/hstn_pkg.sv -----
// ----------------------------------------------------------------------------
// hstn_pkg
// Shared types and constants for the five-point Helmholtz stencil block.
// ----------------------------------------------------------------------------
package hstn_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int FIELD_W   = 16;
    localparam int COEF_W    = 32;
    localparam int TW_W      = 11;
    localparam int K0_W      = 31;
    localparam int OUT_W     = 40;
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 10;
    localparam int PT_W      = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;

    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;
    localparam int SQ_W    = 32;
    localparam int WACC_W  = 63;
    localparam int WT_W    = 40;

    localparam logic [TW_W-1:0]          TILE_WIDTH_RST  = TW_W'(1024);
    localparam logic signed [COEF_W-1:0] COEF_EDGE_RST   = COEF_W'(65536);
    localparam logic signed [COEF_W-1:0] COEF_CENTER_RST = COEF_W'(-262144);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_SQ0,
        OP_SQ1,
        OP_P_LO,
        OP_P_HI,
        OP_A_LO,
        OP_A_HI,
        OP_RE_L,
        OP_RE_R,
        OP_RE_U,
        OP_RE_D,
        OP_RE_C,
        OP_IM_L,
        OP_IM_R,
        OP_IM_U,
        OP_IM_D,
        OP_IM_C,
        OP_RE_P,
        OP_RE_A,
        OP_IM_P,
        OP_IM_A
    } mac_op_t;

    typedef enum logic [2:0] {
        REG_TILE_WIDTH,
        REG_COEF_LEFT,
        REG_COEF_RIGHT,
        REG_COEF_UP,
        REG_COEF_DOWN,
        REG_COEF_CENTER,
        REG_K0_SQUARED,
        REG_ABSORPTION
    } reg_idx_t;

    typedef struct packed {
        logic    capture;
        logic    ram_rd;
        logic    update;
        logic    mul_en;
        mac_op_t op;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/hstn_ram.sv -----
// ----------------------------------------------------------------------------
// hstn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hstn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/hstn_ctrl.sv -----
// ----------------------------------------------------------------------------
// hstn_ctrl
// Sequencer: line-store read, window update, MAC schedule, output load.
// ----------------------------------------------------------------------------
module hstn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hstn_pkg::dp_stat_t stat,
    output hstn_pkg::dp_cmd_t  cmd
);
    import hstn_pkg::*;

    state_t  state_reg, state_next;
    mac_op_t op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_SQ0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.ram_rd = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (stat.emit)
                begin
                    op_next    = OP_SQ0;
                    state_next = ST_MAC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                cmd.mul_en = 1'b1;
                if (op_reg == OP_IM_A)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    op_next = mac_op_t'(op_reg + 5'd1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> $past(state_reg == ST_READ))
        else $error("window update without line-store read");

    a_mac_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && op_reg == OP_SQ0) |-> $past(state_reg == ST_UPDATE))
        else $error("MAC schedule entered out of order");

endmodule

// ----- rtl/core/hstn_dp.sv -----
// ----------------------------------------------------------------------------
// hstn_dp
// Datapath: position counters, two-bank line store, 3x3 window, shared
// 41x17 multiplier with accumulators, rounding/saturation and output word.
// ----------------------------------------------------------------------------
module hstn_dp #(
    parameter int MAX_WIDTH = hstn_pkg::MAX_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  hstn_pkg::dp_cmd_t                        cmd,
    output hstn_pkg::dp_stat_t                       stat,
    input  logic                                     frame_start,
    input  logic signed [hstn_pkg::FIELD_W-1:0]      field_re,
    input  logic signed [hstn_pkg::FIELD_W-1:0]      field_im,
    input  logic [hstn_pkg::FIELD_W-1:0]             index_real,
    input  logic [hstn_pkg::FIELD_W-1:0]             index_imag,
    input  logic [hstn_pkg::TW_W-1:0]                tile_width,
    input  logic signed [hstn_pkg::COEF_W-1:0]       coef_left,
    input  logic signed [hstn_pkg::COEF_W-1:0]       coef_right,
    input  logic signed [hstn_pkg::COEF_W-1:0]       coef_up,
    input  logic signed [hstn_pkg::COEF_W-1:0]       coef_down,
    input  logic signed [hstn_pkg::COEF_W-1:0]       coef_center,
    input  logic [hstn_pkg::K0_W-1:0]                k0_squared,
    input  logic                                     absorption_on,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic signed [hstn_pkg::OUT_W-1:0]        result_re,
    output logic signed [hstn_pkg::OUT_W-1:0]        result_im,
    output logic [hstn_pkg::COL_OUT_W-1:0]           out_col,
    output logic [hstn_pkg::ROW_W-1:0]               out_row
);
    import hstn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > TW_W) ? CW + 1 : TW_W;
    localparam int OW = (CW > COL_OUT_W) ? CW : COL_OUT_W;
    localparam int RW = ACC_W - 16;

    localparam logic [WW-1:0]             W_MIN    = WW'(3);
    localparam logic [WW-1:0]             W_MAX    = WW'(MAX_WIDTH);
    localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(32768);
    localparam logic [WACC_W:0]           WT_HALF  = (WACC_W + 1)'(8388608);

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        logic signed [RW-1:0]    r;
        logic                    ovf;
        s   = acc + RND_HALF;
        r   = s[ACC_W-1:16];
        ovf = !((&r[RW-1:OUT_W-1]) || !(|r[RW-1:OUT_W-1]));
        if (ovf)
        begin
            round_sat = r[RW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            round_sat = r[OUT_W-1:0];
        end
    endfunction

    // position and point
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             bank_reg;
    logic [PT_W-1:0]  pt_reg;
    logic [PT_W-1:0]  win_reg [9];

    logic [PT_W-1:0] rd0, rd1, rd_cur, rd_prev;
    logic [WW-1:0]   tw, w_eff;
    logic            row_end;
    logic [OW-1:0]   col_m2;

    // MAC
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      acc_en_reg;
    mac_op_t                   op_d_reg;
    logic [SQ_W-1:0]           sq0_reg, sq1_reg;
    logic [WACC_W-1:0]         pacc_reg, aacc_reg;
    logic [WT_W-1:0]           p_reg, a_reg;
    logic [WACC_W:0]           p_sum, a_sum;
    logic signed [ACC_W-1:0]   re_acc_reg, im_acc_reg;

    // output word
    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   res_re_reg, res_im_reg;
    logic [COL_OUT_W-1:0]      pend_col_reg, out_col_reg;
    logic [ROW_W-1:0]          pend_row_reg, out_row_reg;

    logic signed [FIELD_W-1:0] l_re, l_im, r_re, r_im, u_re, u_im, d_re, d_im, c_re, c_im;
    logic [FIELD_W-1:0]        c_n0, c_n1, n1_eff;

    assign l_re   = win_reg[3][15:0];
    assign l_im   = win_reg[3][31:16];
    assign r_re   = win_reg[5][15:0];
    assign r_im   = win_reg[5][31:16];
    assign u_re   = win_reg[1][15:0];
    assign u_im   = win_reg[1][31:16];
    assign d_re   = win_reg[7][15:0];
    assign d_im   = win_reg[7][31:16];
    assign c_re   = win_reg[4][15:0];
    assign c_im   = win_reg[4][31:16];
    assign c_n0   = win_reg[4][47:32];
    assign c_n1   = win_reg[4][63:48];
    assign n1_eff = absorption_on ? c_n1 : '0;

    hstn_ram #(.WIDTH(PT_W), .DEPTH(MAX_WIDTH)) u_bank0 (
        .clk   (clk),
        .we    (cmd.update && !bank_reg),
        .waddr (col_reg),
        .wdata (pt_reg),
        .re    (cmd.ram_rd),
        .raddr (col_reg),
        .rdata (rd0)
    );

    hstn_ram #(.WIDTH(PT_W), .DEPTH(MAX_WIDTH)) u_bank1 (
        .clk   (clk),
        .we    (cmd.update && bank_reg),
        .waddr (col_reg),
        .wdata (pt_reg),
        .re    (cmd.ram_rd),
        .raddr (col_reg),
        .rdata (rd1)
    );

    assign rd_cur  = bank_reg ? rd1 : rd0;
    assign rd_prev = bank_reg ? rd0 : rd1;

    assign tw      = WW'(tile_width);
    assign w_eff   = (tw < W_MIN) ? W_MIN : ((tw > W_MAX) ? W_MAX : tw);
    assign row_end = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign col_m2  = OW'(col_reg) - OW'(2);

    assign stat.emit     = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            bank_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.capture)
        begin
            if (frame_start)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                bank_reg <= 1'b0;
            end
        end
        else if (cmd.update)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= rd_cur;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= rd_prev;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= pt_reg;
            if (row_end)
            begin
                col_reg  <= '0;
                bank_reg <= !bank_reg;
                if (row_reg != {ROW_W{1'b1}})
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pt_reg <= {index_imag, index_real, field_im, field_re};
        end
        if (cmd.update)
        begin
            pend_col_reg <= col_m2[COL_OUT_W-1:0];
            pend_row_reg <= row_reg - ROW_W'(2);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQ0:  begin mul_a = MUL_A_W'(c_n0);        mul_b = MUL_B_W'(c_n0);              end
            OP_SQ1:  begin mul_a = MUL_A_W'(n1_eff);      mul_b = MUL_B_W'(n1_eff);            end
            OP_P_LO: begin mul_a = MUL_A_W'(sq0_reg);     mul_b = MUL_B_W'(k0_squared[15:0]);  end
            OP_P_HI: begin mul_a = MUL_A_W'(sq0_reg);     mul_b = MUL_B_W'(k0_squared[30:16]); end
            OP_A_LO: begin mul_a = MUL_A_W'(sq1_reg);     mul_b = MUL_B_W'(k0_squared[15:0]);  end
            OP_A_HI: begin mul_a = MUL_A_W'(sq1_reg);     mul_b = MUL_B_W'(k0_squared[30:16]); end
            OP_RE_L: begin mul_a = MUL_A_W'(coef_left);   mul_b = MUL_B_W'(l_re);              end
            OP_RE_R: begin mul_a = MUL_A_W'(coef_right);  mul_b = MUL_B_W'(r_re);              end
            OP_RE_U: begin mul_a = MUL_A_W'(coef_up);     mul_b = MUL_B_W'(u_re);              end
            OP_RE_D: begin mul_a = MUL_A_W'(coef_down);   mul_b = MUL_B_W'(d_re);              end
            OP_RE_C: begin mul_a = MUL_A_W'(coef_center); mul_b = MUL_B_W'(c_re);              end
            OP_IM_L: begin mul_a = MUL_A_W'(coef_left);   mul_b = MUL_B_W'(l_im);              end
            OP_IM_R: begin mul_a = MUL_A_W'(coef_right);  mul_b = MUL_B_W'(r_im);              end
            OP_IM_U: begin mul_a = MUL_A_W'(coef_up);     mul_b = MUL_B_W'(u_im);              end
            OP_IM_D: begin mul_a = MUL_A_W'(coef_down);   mul_b = MUL_B_W'(d_im);              end
            OP_IM_C: begin mul_a = MUL_A_W'(coef_center); mul_b = MUL_B_W'(c_im);              end
            OP_RE_P: begin mul_a = MUL_A_W'(p_reg);       mul_b = MUL_B_W'(c_re);              end
            OP_RE_A: begin mul_a = MUL_A_W'(a_reg);       mul_b = MUL_B_W'(c_im);              end
            OP_IM_P: begin mul_a = MUL_A_W'(p_reg);       mul_b = MUL_B_W'(c_im);              end
            OP_IM_A: begin mul_a = MUL_A_W'(a_reg);       mul_b = MUL_B_W'(c_re);              end
            default: ;
        endcase
    end

    assign p_sum = {1'b0, pacc_reg} + WT_HALF;
    assign a_sum = {1'b0, aacc_reg} + WT_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        op_d_reg <= cmd.op;
        p_reg    <= p_sum[WACC_W:24];
        a_reg    <= a_sum[WACC_W:24];
        if (acc_en_reg)
        begin
            unique case (op_d_reg)
                OP_SQ0:  sq0_reg    <= prod_reg[SQ_W-1:0];
                OP_SQ1:  sq1_reg    <= prod_reg[SQ_W-1:0];
                OP_P_LO: pacc_reg   <= WACC_W'(prod_reg);
                OP_P_HI: pacc_reg   <= pacc_reg + {prod_reg[WACC_W-17:0], 16'b0};
                OP_A_LO: aacc_reg   <= WACC_W'(prod_reg);
                OP_A_HI: aacc_reg   <= aacc_reg + {prod_reg[WACC_W-17:0], 16'b0};
                OP_RE_L: re_acc_reg <= ACC_W'(prod_reg);
                OP_IM_L: im_acc_reg <= ACC_W'(prod_reg);
                OP_RE_R, OP_RE_U, OP_RE_D, OP_RE_C, OP_RE_P, OP_RE_A:
                    re_acc_reg <= re_acc_reg + ACC_W'(prod_reg);
                OP_IM_R, OP_IM_U, OP_IM_D, OP_IM_C, OP_IM_P:
                    im_acc_reg <= im_acc_reg + ACC_W'(prod_reg);
                OP_IM_A: im_acc_reg <= im_acc_reg - ACC_W'(prod_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_re_reg  <= round_sat(re_acc_reg);
            res_im_reg  <= round_sat(im_acc_reg);
            out_col_reg <= pend_col_reg;
            out_row_reg <= pend_row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_re = res_re_reg;
    assign result_im = res_im_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before taken");

endmodule

// ----- rtl/core/helmholtz_stencil_2d.sv -----
// ----------------------------------------------------------------------------
// helmholtz_stencil_2d
// Five-point Helmholtz operator over a streamed complex tile.
//
// Input words (in_valid/in_ready) carry one point each in raster order, halo
// columns included; frame_start restarts position at row 0, column 0.
// Output words (out_valid/out_ready) carry one interior result with its
// interior column and row, for every point at row >= 2 and column >= 2.
// A point that emits nothing goes through accept, line-store read and
// window update. An emitting point then makes 20 passes through the
// single shared 41x17 multiplier, followed by drain, round and output load.
// The multiplier schedule sets the rate.
// The finished word sits in an output register; the next point is accepted
// while it waits. If the receiver stalls, the block holds the next result
// until the output register frees.
// Reset clears position, window and registers to defaults; the line store is
// not cleared. Registers sit on the APB port at byte address 4*index.
// ----------------------------------------------------------------------------
module helmholtz_stencil_2d #(
    parameter int MAX_WIDTH = hstn_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hstn_pkg::ADDR_W-1:0]         paddr,
    input  logic [hstn_pkg::DATA_W-1:0]         pwdata,
    output logic [hstn_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                frame_start,
    input  logic signed [hstn_pkg::FIELD_W-1:0] field_re,
    input  logic signed [hstn_pkg::FIELD_W-1:0] field_im,
    input  logic [hstn_pkg::FIELD_W-1:0]        index_real,
    input  logic [hstn_pkg::FIELD_W-1:0]        index_imag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hstn_pkg::OUT_W-1:0]   result_re,
    output logic signed [hstn_pkg::OUT_W-1:0]   result_im,
    output logic [hstn_pkg::COL_OUT_W-1:0]      out_col,
    output logic [hstn_pkg::ROW_W-1:0]          out_row
);
    import hstn_pkg::*;

    logic [TW_W-1:0]          tile_width_reg;
    logic signed [COEF_W-1:0] coef_left_reg, coef_right_reg, coef_up_reg;
    logic signed [COEF_W-1:0] coef_down_reg, coef_center_reg;
    logic [K0_W-1:0]          k0_squared_reg;
    logic                     absorption_reg;

    reg_idx_t reg_idx;
    logic     wr_en;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg  <= TILE_WIDTH_RST;
            coef_left_reg   <= COEF_EDGE_RST;
            coef_right_reg  <= COEF_EDGE_RST;
            coef_up_reg     <= COEF_EDGE_RST;
            coef_down_reg   <= COEF_EDGE_RST;
            coef_center_reg <= COEF_CENTER_RST;
            k0_squared_reg  <= '0;
            absorption_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TILE_WIDTH:  tile_width_reg  <= pwdata[TW_W-1:0];
                REG_COEF_LEFT:   coef_left_reg   <= pwdata;
                REG_COEF_RIGHT:  coef_right_reg  <= pwdata;
                REG_COEF_UP:     coef_up_reg     <= pwdata;
                REG_COEF_DOWN:   coef_down_reg   <= pwdata;
                REG_COEF_CENTER: coef_center_reg <= pwdata;
                REG_K0_SQUARED:  k0_squared_reg  <= pwdata[K0_W-1:0];
                REG_ABSORPTION:  absorption_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TILE_WIDTH:  prdata = DATA_W'(tile_width_reg);
            REG_COEF_LEFT:   prdata = coef_left_reg;
            REG_COEF_RIGHT:  prdata = coef_right_reg;
            REG_COEF_UP:     prdata = coef_up_reg;
            REG_COEF_DOWN:   prdata = coef_down_reg;
            REG_COEF_CENTER: prdata = coef_center_reg;
            REG_K0_SQUARED:  prdata = DATA_W'(k0_squared_reg);
            REG_ABSORPTION:  prdata = DATA_W'(absorption_reg);
        endcase
    end

    hstn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hstn_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .frame_start   (frame_start),
        .field_re      (field_re),
        .field_im      (field_im),
        .index_real    (index_real),
        .index_imag    (index_imag),
        .tile_width    (tile_width_reg),
        .coef_left     (coef_left_reg),
        .coef_right    (coef_right_reg),
        .coef_up       (coef_up_reg),
        .coef_down     (coef_down_reg),
        .coef_center   (coef_center_reg),
        .k0_squared    (k0_squared_reg),
        .absorption_on (absorption_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .result_re     (result_re),
        .result_im     (result_im),
        .out_col       (out_col),
        .out_row       (out_row)
    );

endmodule

// ----- verif/tb_helmholtz_stencil_2d.sv -----
// ----------------------------------------------------------------------------
// tb_helmholtz_stencil_2d
// Self-checking testbench for the five-point Helmholtz stencil block.
//
// Streams complex tiles into the block and computes the expected operator
// output for every interior point with a bit-accurate predictor of its own.
// Each output word is compared field by field with the oldest expected word.
// Directed tests cover the field and register extremes, width clamping and
// a width cut in the middle of a row. A long random run follows, with idle
// and stall gaps on both sides.
// ----------------------------------------------------------------------------
module tb_helmholtz_stencil_2d;

    timeunit 1ns;
    timeprecision 1ps;

    import hstn_pkg::*;

    localparam int MAXW        = MAX_WIDTH_DEF;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic [OUT_W-1:0]     re;
        logic [OUT_W-1:0]     im;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
    } op_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic frame_start;
    logic signed [FIELD_W-1:0] field_re;
    logic signed [FIELD_W-1:0] field_im;
    logic [FIELD_W-1:0] index_real;
    logic [FIELD_W-1:0] index_imag;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_W-1:0] result_re;
    logic signed [OUT_W-1:0] result_im;
    logic [COL_OUT_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;

    helmholtz_stencil_2d i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_start (frame_start),
        .field_re    (field_re),
        .field_im    (field_im),
        .index_real  (index_real),
        .index_imag  (index_imag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_re   (result_re),
        .result_im   (result_im),
        .out_col     (out_col),
        .out_row     (out_row)
    );

    // predictor state
    logic [63:0] line_mem [2*MAXW];
    logic [63:0] win [9];
    int unsigned col_pos;
    int unsigned row_pos;
    bit          bank_sel;
    logic [10:0] cfg_width;
    logic [31:0] cfg_cl, cfg_cr, cfg_cu, cfg_cd, cfg_cc;
    logic [30:0] cfg_k0;
    bit          cfg_abs;

    op_result_t expected_q [$];
    int  n_errors;
    int  n_words_in;
    int  n_words_out;
    bit  gaps_on;
    int  idle_cycles;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint s16(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint s32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint index_weight(input logic [15:0] n);
        longint unsigned sq;
        sq = longint'(n) * longint'(n);
        return longint'((sq * longint'(cfg_k0) + 64'd8388608) >> 24);
    endfunction

    function automatic logic [OUT_W-1:0] round_sat(input longint acc);
        longint r;
        r = (acc + 64'sd32768) >>> 16;
        if (r > 64'sd549755813887)
            r = 64'sd549755813887;
        if (r < -64'sd549755813888)
            r = -64'sd549755813888;
        return r[OUT_W-1:0];
    endfunction

    task automatic stencil_step(input logic fs, input logic [15:0] re, input logic [15:0] im,
                                input logic [15:0] n0, input logic [15:0] n1);
        int unsigned w;
        int unsigned x;
        logic [63:0] pt;
        logic [63:0] c;
        longint lre, lim, p, a, cre, cim;
        op_result_t r;
        w = cfg_width;
        if (w < 3)
            w = 3;
        if (w > MAXW)
            w = MAXW;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
            bank_sel = 1'b0;
        end
        x = (col_pos >= MAXW) ? MAXW - 1 : col_pos;
        pt = {n1, n0, im, re};
        for (int k = 0; k < 3; k++)
        begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = line_mem[bank_sel*MAXW + x];
        win[5] = line_mem[(!bank_sel)*MAXW + x];
        win[8] = pt;
        line_mem[bank_sel*MAXW + x] = pt;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            c = win[4];
            cre = s16(c[15:0]);
            cim = s16(c[31:16]);
            p = index_weight(c[47:32]);
            a = cfg_abs ? index_weight(c[63:48]) : 0;
            lre = s32(cfg_cl) * s16(win[3][15:0]) + s32(cfg_cr) * s16(win[5][15:0])
                + s32(cfg_cu) * s16(win[1][15:0]) + s32(cfg_cd) * s16(win[7][15:0])
                + s32(cfg_cc) * cre;
            lim = s32(cfg_cl) * s16(win[3][31:16]) + s32(cfg_cr) * s16(win[5][31:16])
                + s32(cfg_cu) * s16(win[1][31:16]) + s32(cfg_cd) * s16(win[7][31:16])
                + s32(cfg_cc) * cim;
            lre += p * cre + a * cim;
            lim += p * cim - a * cre;
            r.re = round_sat(lre);
            r.im = round_sat(lim);
            r.col = COL_OUT_W'(col_pos - 2);
            r.row = ROW_W'(row_pos - 2);
            expected_q.push_back(r);
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos < 65535)
                row_pos++;
            bank_sel = !bank_sel;
        end
        else
            col_pos++;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        n_errors++;
        $display("MISMATCH %s: got %0h expected %0h (word %0d)", what, got, want, n_words_out);
    endtask

    always @(posedge clk)
    begin
        op_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $display("MISMATCH unexpected output word at row %0d col %0d", out_row, out_col);
            end
            else
            begin
                e = expected_q.pop_front();
                if (result_re !== e.re)
                    report("result_re", result_re, $signed(e.re));
                if (result_im !== e.im)
                    report("result_im", result_im, $signed(e.im));
                if (out_col !== e.col)
                    report("out_col", out_col, e.col);
                if (out_row !== e.row)
                    report("out_row", out_row, e.row);
            end
            n_words_out++;
        end
    end

    // receiver: random stalls before each word
    initial begin
        int k;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            k = gaps_on ? $urandom_range(0, 16) : 0;
            if (k > 0)
            begin
                out_ready = 1'b0;
                repeat (k) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(int'(idx) * 4);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_TILE_WIDTH:  cfg_width = value[10:0];
            REG_COEF_LEFT:   cfg_cl = value;
            REG_COEF_RIGHT:  cfg_cr = value;
            REG_COEF_UP:     cfg_cu = value;
            REG_COEF_DOWN:   cfg_cd = value;
            REG_COEF_CENTER: cfg_cc = value;
            REG_K0_SQUARED:  cfg_k0 = value[30:0];
            REG_ABSORPTION:  cfg_abs = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_all(input logic [31:0] w, input logic [31:0] cl, input logic [31:0] cr,
                             input logic [31:0] cu, input logic [31:0] cd, input logic [31:0] cc,
                             input logic [31:0] k0, input logic [31:0] ab);
        reg_write(REG_TILE_WIDTH, w);
        reg_write(REG_COEF_LEFT, cl);
        reg_write(REG_COEF_RIGHT, cr);
        reg_write(REG_COEF_UP, cu);
        reg_write(REG_COEF_DOWN, cd);
        reg_write(REG_COEF_CENTER, cc);
        reg_write(REG_K0_SQUARED, k0);
        reg_write(REG_ABSORPTION, ab);
    endtask

    task automatic send_point(input logic fs, input logic [15:0] re, input logic [15:0] im,
                              input logic [15:0] n0, input logic [15:0] n1);
        int k;
        k = gaps_on ? $urandom_range(0, 16) : 0;
        if (k > 0)
        begin
            in_valid = 1'b0;
            repeat (k) @(negedge clk);
        end
        frame_start = fs;
        field_re = re;
        field_im = im;
        index_real = n0;
        index_imag = n1;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        stencil_step(fs, re, im, n0, n1);
        n_words_in++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rnd_coef();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom_range(0, 1) ? 32'($urandom) : 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic send_random_point(input logic fs);
        send_point(fs, rnd16(), rnd16(), rnd16(), rnd16());
    endtask

    task automatic test_no_frame_start();
        logic [15:0] v;
        write_all(5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'hfffc0000, 32'h10000, 1);
        for (int i = 0; i < 15; i++)
        begin
            v = (i % 2) ? 16'h7fff : 16'h8000;
            send_point(1'b0, v, ~v, (i % 3 == 0) ? 16'hffff : 16'h1000, 16'(i * 4096));
        end
        wait_idle();
    endtask

    task automatic test_extremes_small_width();
        write_all(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h7fffffff, 1);
        for (int i = 0; i < 9; i++)
            send_point(i == 0, (i % 2) ? 16'h8000 : 16'h7fff, (i % 2) ? 16'h7fff : 16'h8000,
                       16'hffff, 16'hffff);
        wait_idle();
        reg_write(REG_TILE_WIDTH, 2);
        reg_write(REG_K0_SQUARED, 0);
        reg_write(REG_ABSORPTION, 0);
        for (int i = 0; i < 9; i++)
            send_random_point(i == 0);
        wait_idle();
    endtask

    task automatic test_random_tiles();
        int w;
        int rows;
        int sent;
        int phase;
        sent = 0;
        phase = 0;
        while (sent < 870)
        begin
            gaps_on = (phase % 4) != 3;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            write_all(w, rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(),
                      ($urandom_range(0, 3) == 0) ? 32'h7fffffff : $urandom_range(0, 32'h7fffff),
                      $urandom_range(0, 1));
            if (w < 3)
                w = 3;
            rows = $urandom_range(3, 6);
            for (int i = 0; i < w * rows; i++)
            begin
                // an occasional restart in the middle of a tile
                send_random_point(i == 0 || $urandom_range(0, 49) == 0);
                sent++;
                if (phase == 2 && i == w * 2)
                    wait_idle();
            end
            wait_idle();
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_width_cut_mid_row();
        write_all(8, rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), 32'h30000, 1);
        for (int i = 0; i < 21; i++)
            send_random_point(i == 0);
        wait_idle();
        reg_write(REG_TILE_WIDTH, 4);
        for (int i = 0; i < 14; i++)
            send_random_point(1'b0);
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        frame_start = 1'b0;
        field_re = '0;
        field_im = '0;
        index_real = '0;
        index_imag = '0;
        n_errors = 0;
        n_words_in = 0;
        n_words_out = 0;
        gaps_on = 1'b1;
        idle_cycles = 0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (win[i])
            win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        bank_sel = 1'b0;
        cfg_width = TILE_WIDTH_RST;
        cfg_cl = COEF_EDGE_RST;
        cfg_cr = COEF_EDGE_RST;
        cfg_cu = COEF_EDGE_RST;
        cfg_cd = COEF_EDGE_RST;
        cfg_cc = COEF_CENTER_RST;
        cfg_k0 = '0;
        cfg_abs = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_frame_start();
        test_extremes_small_width();
        test_width_cut_mid_row();
        test_random_tiles();

        $display("Run covered %0d input words and %0d output words: width clamping,", n_words_in,
                 n_words_out);
        $display("stream without frame start, mid-row width cut and random tiles.");
        if (n_errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d words still expected", n_errors, expected_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hstn_pkg.sv
rtl/core/hstn_ram.sv
rtl/core/hstn_ctrl.sv
rtl/core/hstn_dp.sv
rtl/core/helmholtz_stencil_2d.sv
verif/tb_helmholtz_stencil_2d.sv
